@@ sv/blr_pkg.sv @@
// shared constants, types and control structs for the line rasterizer
// no dependencies; compiled first
package blr_pkg;

   localparam int COORD_BITS    = 6;
   localparam int COLOR_BITS    = 8;
   // decision term spans roughly -2^(COORD_BITS+1) .. 2^(COORD_BITS+1)-1
   localparam int DECISION_BITS = COORD_BITS + 2;

   typedef logic [COORD_BITS-1:0]           coord_type;
   typedef logic [COLOR_BITS-1:0]           color_type;
   typedef logic signed [DECISION_BITS-1:0] decision_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture the line command
      logic setup_a;   // pick the major axis
      logic setup_b;   // order endpoints, init decision term
      logic step;      // emit one pixel and advance
   } blr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;      // pixel about to be emitted is the end of the run
   } blr_stat_type;

endpackage

@@ sv/blr_req_if.sv @@
// line command channel: valid/ready plus endpoints and color
// depends on blr_pkg
interface blr_req_if;
   import blr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   color_type line_color;

   modport source (
      output valid, start_x, start_y, end_x, end_y, line_color,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, end_x, end_y, line_color,
      output ready
   );

endinterface

@@ sv/blr_rsp_if.sv @@
// pixel channel: valid/ready plus pixel coordinates, color and end marker
// depends on blr_pkg
interface blr_rsp_if;
   import blr_pkg::*;

   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   color_type pixel_color;
   logic      last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
      output ready
   );

endinterface

@@ sv/blr_ctrl.sv @@
// sequencer for the rasterizer: handshakes and datapath commands
// depends on blr_pkg
module blr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output blr_pkg::blr_cmd_type  cmd,
   input  blr_pkg::blr_stat_type stat
);
   import blr_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SETUP_A,
      SETUP_B,
      RUN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      step;

   assign accept    = req_valid && (state_ff == IDLE);
   // output register free or being emptied this cycle
   assign step      = (state_ff == RUN) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load    = accept;
      cmd.setup_a = (state_ff == SETUP_A);
      cmd.setup_b = (state_ff == SETUP_B);
      cmd.step    = step;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE:    if (accept) state_in = SETUP_A;
         SETUP_A: state_in = SETUP_B;
         SETUP_B: state_in = RUN;
         RUN:     if (step && stat.last) state_in = IDLE;
         default: state_in = IDLE;
      endcase

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/blr_dpath.sv @@
// rasterizer datapath: command registers, axis setup, decision stepper, pixel register
// depends on blr_pkg
module blr_dpath (
   input  logic                  clock,
   input  blr_pkg::blr_cmd_type  cmd,
   output blr_pkg::blr_stat_type stat,
   input  blr_pkg::coord_type    start_x,
   input  blr_pkg::coord_type    start_y,
   input  blr_pkg::coord_type    end_x,
   input  blr_pkg::coord_type    end_y,
   input  blr_pkg::color_type    line_color,
   output blr_pkg::coord_type    pixel_x,
   output blr_pkg::coord_type    pixel_y,
   output blr_pkg::color_type    pixel_color,
   output logic                  last_pixel
);
   import blr_pkg::*;

   function automatic coord_type abs_diff(input coord_type a, input coord_type b);
      abs_diff = (a > b) ? coord_type'(a - b) : coord_type'(b - a);
   endfunction

   // captured command
   coord_type    x0_ff, y0_ff, x1_ff, y1_ff;
   color_type    color_ff;
   logic         x_major_ff;

   // walker state
   coord_type    ma_ff, mi_ff, cnt_ff;
   logic         inc_up_ff;
   decision_type d_ff, d_in;
   decision_type inc_lo_ff;   // 2*minor
   decision_type inc_hi_ff;   // 2*(minor - major)

   // pixel output register
   coord_type    pixel_x_ff, pixel_y_ff;
   color_type    pixel_color_ff;
   logic         last_pixel_ff;

   // setup logic
   coord_type    ma0, mi0, ma1, mi1;
   coord_type    s_ma, s_mi, e_ma, e_mi;
   coord_type    major_w, minor_w;
   logic         swap;
   decision_type two_minor, two_major;

   always_comb begin
      ma0  = x_major_ff ? x0_ff : y0_ff;
      mi0  = x_major_ff ? y0_ff : x0_ff;
      ma1  = x_major_ff ? x1_ff : y1_ff;
      mi1  = x_major_ff ? y1_ff : x1_ff;
      swap = (ma0 > ma1);
      s_ma = swap ? ma1 : ma0;
      s_mi = swap ? mi1 : mi0;
      e_ma = swap ? ma0 : ma1;
      e_mi = swap ? mi0 : mi1;
      major_w   = coord_type'(e_ma - s_ma);
      minor_w   = abs_diff(s_mi, e_mi);
      two_minor = decision_type'({1'b0, minor_w, 1'b0});
      two_major = decision_type'({1'b0, major_w, 1'b0});
   end

   // minor axis steps when the term is non-negative
   always_comb begin
      if (!d_ff[DECISION_BITS-1]) begin
         d_in = decision_type'(d_ff + inc_hi_ff);
      end else begin
         d_in = decision_type'(d_ff + inc_lo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff    <= start_x;
         y0_ff    <= start_y;
         x1_ff    <= end_x;
         y1_ff    <= end_y;
         color_ff <= line_color;
      end
      if (cmd.setup_a) begin
         // x wins a tie
         x_major_ff <= (abs_diff(x0_ff, x1_ff) >= abs_diff(y0_ff, y1_ff));
      end
      if (cmd.setup_b) begin
         ma_ff     <= s_ma;
         mi_ff     <= s_mi;
         cnt_ff    <= major_w;
         inc_up_ff <= (e_mi > s_mi);
         d_ff      <= decision_type'(two_minor - decision_type'({2'b00, major_w}));
         inc_lo_ff <= two_minor;
         inc_hi_ff <= decision_type'(two_minor - two_major);
      end
      if (cmd.step) begin
         pixel_x_ff     <= x_major_ff ? ma_ff : mi_ff;
         pixel_y_ff     <= x_major_ff ? mi_ff : ma_ff;
         pixel_color_ff <= color_ff;
         last_pixel_ff  <= (cnt_ff == '0);
         d_ff           <= d_in;
         ma_ff          <= coord_type'(ma_ff + 1'b1);
         cnt_ff         <= coord_type'(cnt_ff - 1'b1);
         if (!d_ff[DECISION_BITS-1]) begin
            mi_ff <= inc_up_ff ? coord_type'(mi_ff + 1'b1) : coord_type'(mi_ff - 1'b1);
         end
      end
   end

   assign stat.last   = (cnt_ff == '0);
   assign pixel_x     = pixel_x_ff;
   assign pixel_y     = pixel_y_ff;
   assign pixel_color = pixel_color_ff;
   assign last_pixel  = last_pixel_ff;

endmodule

@@ sv/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer. Each item on req_bus is a line command (two endpoints
// and a color); rsp_bus returns every pixel of the integer Bresenham line between
// them, major axis increasing (x wins a tie), color copied, last_pixel set on the
// final pixel; equal endpoints give a single pixel. After a command is taken the
// block passes through the setup states SETUP_A (pick the major axis) and SETUP_B
// (order endpoints, init decision term), then emits one pixel per cycle from the
// stepping unit while rsp_bus is ready; a line with major extent N gives N+1 pixels.
// The next command is taken as soon as the final pixel sits in the output register.
// depends on blr_pkg, blr_req_if, blr_rsp_if, blr_ctrl, blr_dpath
module bresenham_line_rasterizer (
   input  logic       clock,
   input  logic       reset,
   blr_req_if.sink    req_bus,
   blr_rsp_if.source  rsp_bus
);
   import blr_pkg::*;

   blr_cmd_type  cmd;
   blr_stat_type stat;

   blr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   blr_dpath u_dpath (
      .clock       (clock),
      .cmd         (cmd),
      .stat        (stat),
      .start_x     (req_bus.start_x),
      .start_y     (req_bus.start_y),
      .end_x       (req_bus.end_x),
      .end_y       (req_bus.end_y),
      .line_color  (req_bus.line_color),
      .pixel_x     (rsp_bus.pixel_x),
      .pixel_y     (rsp_bus.pixel_y),
      .pixel_color (rsp_bus.pixel_color),
      .last_pixel  (rsp_bus.last_pixel)
   );

endmodule

@@ sv/blr_checker.sv @@
// port-level checks for the line rasterizer, bound to the top level
// depends on blr_pkg and bresenham_line_rasterizer
module blr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input blr_pkg::coord_type pixel_x,
   input blr_pkg::coord_type pixel_y,
   input blr_pkg::color_type pixel_color,
   input logic               last_pixel
);
   import blr_pkg::*;

   // stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y)
         && $stable(pixel_color) && $stable(last_pixel))
      else $error("stalled pixel changed");

   // one command at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while another is in setup");

   // pixels of a new command never show right after it is taken
   a_no_early_pixel: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(rsp_valid && !last_pixel))
      else $error("pixel appeared before setup finished");

   // run continues back to back with the same color
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_pixel |=> rsp_valid && $stable(pixel_color))
      else $error("pixel run broken or color changed");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .pixel_x     (rsp_bus.pixel_x),
   .pixel_y     (rsp_bus.pixel_y),
   .pixel_color (rsp_bus.pixel_color),
   .last_pixel  (rsp_bus.last_pixel)
);

@@ bench/blr_line_checker.sv @@
// watches the line command and pixel channels, predicts the pixel run of each command
// and compares every pixel field by field; depends on blr_pkg, blr_req_if, blr_rsp_if
module blr_line_checker (
   input  logic clock,
   input  logic reset,
   blr_req_if   req_mon,
   blr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pixels_pending
);
   import blr_pkg::*;

   typedef struct {
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } pixel_type;

   pixel_type pixel_queue[$];

   // integer bresenham on the major axis, endpoints ordered so the major coordinate rises
   function automatic void rasterize(coord_type x_a, coord_type y_a, coord_type x_b,
                                     coord_type y_b, color_type color);
      int ax, ay, bx, by;
      int ext_x, ext_y, ma0, mi0, ma1, mi1, swap_tmp;
      int major, minor, dir, decision, ma, mi;
      bit x_major;
      pixel_type pix;
      ax = x_a;
      ay = y_a;
      bx = x_b;
      by = y_b;
      ext_x = (ax > bx) ? ax - bx : bx - ax;
      ext_y = (ay > by) ? ay - by : by - ay;
      x_major = (ext_x >= ext_y);
      if (x_major) begin
         ma0 = ax; mi0 = ay; ma1 = bx; mi1 = by;
      end else begin
         ma0 = ay; mi0 = ax; ma1 = by; mi1 = bx;
      end
      if (ma0 > ma1) begin
         swap_tmp = ma0; ma0 = ma1; ma1 = swap_tmp;
         swap_tmp = mi0; mi0 = mi1; mi1 = swap_tmp;
      end
      major = ma1 - ma0;
      minor = (mi0 > mi1) ? mi0 - mi1 : mi1 - mi0;
      dir = (mi1 > mi0) ? 1 : -1;
      decision = 2 * minor - major;
      ma = ma0;
      mi = mi0;
      for (int i = 0; i <= major; i++) begin
         pix.x = coord_type'(x_major ? ma : mi);
         pix.y = coord_type'(x_major ? mi : ma);
         pix.color = color;
         pix.last = (i == major);
         pixel_queue.push_back(pix);
         if (decision >= 0) begin
            mi += dir;
            decision += 2 * (minor - major);
         end else begin
            decision += 2 * minor;
         end
         ma++;
      end
   endfunction

   function automatic int field_check(string name, int want, int got);
      if (want != got) begin
         $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      int errs;
      pixel_type want;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         pixels_pending <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            rasterize(req_mon.start_x, req_mon.start_y, req_mon.end_x, req_mon.end_y,
                      req_mon.line_color);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d", $time,
                        rsp_mon.pixel_x, rsp_mon.pixel_y);
               errs = 1;
            end else begin
               want = pixel_queue.pop_front();
               errs += field_check("x", want.x, rsp_mon.pixel_x);
               errs += field_check("y", want.y, rsp_mon.pixel_y);
               errs += field_check("color", want.color, rsp_mon.pixel_color);
               errs += field_check("last", want.last, rsp_mon.last_pixel);
            end
         end
         fail_count <= fail_count + errs;
         pixels_pending <= pixel_queue.size();
      end
   end

endmodule

@@ bench/bresenham_line_rasterizer_test.sv @@
// top of the line rasterizer bench: clock, reset, line command stimulus and
// pixel back-pressure; depends on blr_pkg, both channel interfaces and blr_line_checker
module bresenham_line_rasterizer_test;
   import blr_pkg::*;

   localparam int RANDOM_LINES = 360;
   localparam int CYCLE_LIMIT  = 4_000_000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pixels_pending;
   int   cycle_count = 0;
   int   stall_left = 0;
   bit   source_gaps;
   bit   sink_stalls;

   blr_req_if req_bus ();
   blr_rsp_if rsp_bus ();

   bresenham_line_rasterizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   blr_line_checker u_line_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (sink_stalls && $urandom_range(0, 3) == 0) stall_left = pause_length();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, pixels_pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_line(coord_type x_a, coord_type y_a, coord_type x_b, coord_type y_b,
                            color_type color);
      int gap;
      gap = (source_gaps && $urandom_range(0, 2) == 0) ? pause_length() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.start_x    <= x_a;
      req_bus.start_y    <= y_a;
      req_bus.end_x      <= x_b;
      req_bus.end_y      <= y_b;
      req_bus.line_color <= color;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_random_line();
      coord_type x_a, y_a, x_b, y_b, swap_tmp;
      int kind, span;
      kind = $urandom_range(0, 9);
      x_a = coord_type'($urandom);
      y_a = coord_type'($urandom);
      x_b = coord_type'($urandom);
      y_b = coord_type'($urandom);
      case (kind)
         4, 5: begin
            // short line, wraps at the panel edge
            x_b = x_a + coord_type'($urandom_range(0, 6)) - 6'd3;
            y_b = y_a + coord_type'($urandom_range(0, 6)) - 6'd3;
         end
         6: y_b = y_a;
         7: x_b = x_a;
         8: begin
            // equal extents on both axes
            span = $urandom_range(0, 63);
            x_a = coord_type'($urandom_range(0, 63 - span));
            y_a = coord_type'($urandom_range(0, 63 - span));
            x_b = x_a + coord_type'(span);
            y_b = y_a + coord_type'(span);
            if ($urandom_range(0, 1)) begin
               swap_tmp = y_a; y_a = y_b; y_b = swap_tmp;
            end
            if ($urandom_range(0, 1)) begin
               swap_tmp = x_a; x_a = x_b; x_b = swap_tmp;
            end
         end
         9: begin
            x_b = x_a;
            y_b = y_a;
         end
         default: ;
      endcase
      send_line(x_a, y_a, x_b, y_b, color_type'($urandom));
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.start_x    <= '0;
      req_bus.start_y    <= '0;
      req_bus.end_x      <= '0;
      req_bus.end_y      <= '0;
      req_bus.line_color <= '0;
      source_gaps        <= 1'b0;
      sink_stalls        <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_line(6'd0, 6'd0, 6'd0, 6'd0, 8'h00);
      send_line(6'd63, 6'd63, 6'd63, 6'd63, 8'hFF);
      send_line(6'd0, 6'd0, 6'd63, 6'd0, 8'hA5);
      send_line(6'd63, 6'd63, 6'd0, 6'd63, 8'h5A);
      send_line(6'd0, 6'd0, 6'd0, 6'd63, 8'h0F);
      send_line(6'd63, 6'd63, 6'd63, 6'd0, 8'hF0);
      send_line(6'd0, 6'd0, 6'd63, 6'd63, 8'h3C);
      send_line(6'd63, 6'd0, 6'd0, 6'd63, 8'hC3);
      send_line(6'd0, 6'd63, 6'd63, 6'd0, 8'h81);
      send_line(6'd10, 6'd20, 6'd50, 6'd30, 8'h42);
      send_line(6'd50, 6'd30, 6'd10, 6'd20, 8'h24);
      send_line(6'd20, 6'd10, 6'd30, 6'd50, 8'h18);
      send_line(6'd30, 6'd50, 6'd20, 6'd10, 8'hE7);
      send_line(6'd5, 6'd40, 6'd60, 6'd2, 8'h99);
      send_line(6'd40, 6'd5, 6'd2, 6'd60, 8'h66);
      send_line(6'd7, 6'd7, 6'd8, 6'd8, 8'h11);
      send_line(6'd7, 6'd7, 6'd8, 6'd7, 8'h22);
      send_line(6'd0, 6'd31, 6'd63, 6'd32, 8'h77);
      send_line(6'd31, 6'd0, 6'd32, 6'd63, 8'hEE);

      // phases: no idling, both sides idle, receiver stalls only, sender gaps only
      for (int n = 0; n < RANDOM_LINES; n++) begin
         source_gaps <= (n / 90 == 1) || (n / 90 == 3);
         sink_stalls <= (n / 90 == 1) || (n / 90 == 2);
         send_random_line();
      end
      req_bus.valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/blr_pkg.sv
sv/blr_req_if.sv
sv/blr_rsp_if.sv
sv/blr_ctrl.sv
sv/blr_dpath.sv
sv/bresenham_line_rasterizer.sv
sv/blr_checker.sv
bench/blr_line_checker.sv
bench/bresenham_line_rasterizer_test.sv
